>>> design/icr_pkg.sv
// icr_pkg: shared types and constants for the impulse collision resolver
// transaction payloads, outcome codes, pipeline context records
// no dependencies
package icr_pkg;

  localparam int unsigned VelW    = 32;
  localparam int unsigned MassW   = 32;
  localparam int unsigned RestW   = 15;
  localparam int unsigned NormW   = 16;
  localparam int unsigned QuotW   = 24;   // mass ratio fraction bits
  localparam int unsigned DivSteps = QuotW;
  localparam logic [RestW-1:0] OneQ14 = 15'd16384;

  typedef enum logic [1:0] {
    OUT_APPLIED    = 2'd0,
    OUT_SEPARATING = 2'd1,
    OUT_ZERO_MASS  = 2'd2,
    OUT_SATURATED  = 2'd3
  } outcome_t;

  typedef struct packed {
    logic signed [VelW-1:0]  first_vel_x;
    logic signed [VelW-1:0]  first_vel_y;
    logic signed [VelW-1:0]  second_vel_x;
    logic signed [VelW-1:0]  second_vel_y;
    logic        [MassW-1:0] first_mass;
    logic        [MassW-1:0] second_mass;
    logic        [RestW-1:0] first_restitution;
    logic        [RestW-1:0] second_restitution;
    logic signed [NormW-1:0] normal_x;
    logic signed [NormW-1:0] normal_y;
  } icr_in_t;

  typedef struct packed {
    logic signed [VelW-1:0] new_first_vel_x;
    logic signed [VelW-1:0] new_first_vel_y;
    logic signed [VelW-1:0] new_second_vel_x;
    logic signed [VelW-1:0] new_second_vel_y;
    logic        [1:0]      outcome;
  } icr_out_t;

  // context carried beside the divider
  typedef struct packed {
    logic signed [VelW-1:0]  v1x;
    logic signed [VelW-1:0]  v1y;
    logic signed [VelW-1:0]  v2x;
    logic signed [VelW-1:0]  v2y;
    logic signed [NormW-1:0] nx;
    logic signed [NormW-1:0] ny;
    logic                    zero_mass;
    logic                    sep;
    logic signed [32:0]      rx;
    logic signed [32:0]      ry;
    logic        [15:0]      k;
    logic signed [48:0]      px;
    logic signed [48:0]      py;
    logic        [48:0]      negvn;
    logic        [40:0]      plo;
    logic        [39:0]      phi;
    logic        [35:0]      s;
  } icr_ctx_t;

  typedef struct packed {
    logic [32:0]      sum;
    logic [32:0]      rem;
    logic [QuotW-1:0] quot;
  } icr_div_t;

endpackage

>>> design/icr_in_if.sv
// icr_in_if / icr_out_if: valid-ready channels for the resolver
// depends on icr_pkg
interface icr_in_if;
  import icr_pkg::*;
  logic    valid;
  logic    ready;
  icr_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface icr_out_if;
  import icr_pkg::*;
  logic     valid;
  logic     ready;
  icr_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/impulse_collision_resolve.sv
// impulse_collision_resolve: 2D impulse collision response, fixed point
// each transaction runs capture, divider and stages F..K into rsp
// throughput one transaction per cycle unless rsp stalls; the mass ratio
// comes from a 24-stage restoring divider, one quotient bit per stage
// whole pipeline stalls together while a result waits on rsp
// rst (synchronous) clears all valid bits; payload registers are not reset
// depends on icr_pkg, icr_in_if, icr_out_if
module impulse_collision_resolve (
  input logic clk,
  input logic rst,
  icr_in_if.sink    req,
  icr_out_if.source rsp
);
  import icr_pkg::*;

  // global advance: move when the output slot is free or being taken
  logic en;
  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  // divider-aligned section: index 0 is the capture stage, index i holds
  // the state after i quotient steps
  icr_ctx_t cx  [0:DivSteps];
  icr_div_t dv  [0:DivSteps];
  logic     vld [0:DivSteps];

  // capture: relative velocity, restitution choice, mass sum
  logic [RestW-1:0] e_min;
  icr_ctx_t         cx_in;
  icr_div_t         dv_in;

  always_comb begin
    e_min = (req.data.first_restitution < req.data.second_restitution) ?
            req.data.first_restitution : req.data.second_restitution;
    if (e_min > OneQ14) begin
      e_min = OneQ14;
    end
    cx_in           = '0;
    cx_in.v1x       = req.data.first_vel_x;
    cx_in.v1y       = req.data.first_vel_y;
    cx_in.v2x       = req.data.second_vel_x;
    cx_in.v2y       = req.data.second_vel_y;
    cx_in.nx        = req.data.normal_x;
    cx_in.ny        = req.data.normal_y;
    cx_in.zero_mass = (req.data.first_mass == '0) || (req.data.second_mass == '0);
    cx_in.rx        = 33'(req.data.second_vel_x) - 33'(req.data.first_vel_x);
    cx_in.ry        = 33'(req.data.second_vel_y) - 33'(req.data.first_vel_y);
    cx_in.k         = 16'(OneQ14) + 16'(e_min);
    dv_in.sum       = 33'(req.data.first_mass) + 33'(req.data.second_mass);
    dv_in.rem       = 33'(req.data.second_mass);
    dv_in.quot      = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= req.valid;
    end
    if (en) begin
      cx[0] <= cx_in;
      dv[0] <= dv_in;
    end
  end

  // one quotient bit per stage; the first stages also finish vn and s
  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    icr_ctx_t           cn;
    icr_div_t           dn;
    logic [33:0]        rem_sh;
    logic signed [49:0] vn;
    logic [64:0]        t65;

    always_comb begin
      rem_sh = {dv[i].rem, 1'b0};
      dn     = dv[i];
      if (rem_sh >= {1'b0, dv[i].sum}) begin
        dn.rem  = 33'(rem_sh - {1'b0, dv[i].sum});
        dn.quot = {dv[i].quot[QuotW-2:0], 1'b1};
      end else begin
        dn.rem  = rem_sh[32:0];
        dn.quot = {dv[i].quot[QuotW-2:0], 1'b0};
      end

      cn  = cx[i];
      vn  = '0;
      t65 = '0;
      if (i == 0) begin
        // projection products
        cn.px = 49'(cx[i].rx) * 49'(cx[i].nx);
        cn.py = 49'(cx[i].ry) * 49'(cx[i].ny);
      end
      if (i == 1) begin
        vn       = 50'(cx[i].px) + 50'(cx[i].py);
        cn.sep   = (vn > 50'sd0);
        cn.negvn = 49'(-vn);
      end
      if (i == 2) begin
        // (1+e)*|vn| split in two partial products
        cn.plo = 41'(cx[i].k) * 41'(cx[i].negvn[24:0]);
        cn.phi = 40'(cx[i].k) * 40'(cx[i].negvn[48:25]);
      end
      if (i == 3) begin
        t65  = 65'(cx[i].plo) + {cx[i].phi, 25'b0} + (65'd1 << 27);
        cn.s = t65[63:28];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        cx[i+1] <= cn;
        dv[i+1] <= dn;
      end
    end
  end

  // tail stages: ratios, velocity changes, saturation
  typedef struct packed {
    logic signed [VelW-1:0]  v1x;
    logic signed [VelW-1:0]  v1y;
    logic signed [VelW-1:0]  v2x;
    logic signed [VelW-1:0]  v2y;
    logic                    nxn;
    logic                    nyn;
    logic [NormW-1:0]        anx;
    logic [NormW-1:0]        any_n;
    logic                    zero_mass;
    logic                    sep;
  } tail_t;

  localparam int unsigned TailN = 5;

  tail_t        tl  [0:TailN-1];
  logic         tv  [0:TailN-1];

  logic [35:0]  s_f;
  logic [24:0]  r1_f, r2_f;
  logic [42:0]  p1lo, p1hi, p2lo, p2hi;
  logic [36:0]  d1, d2;
  logic [52:0]  q1x, q1y, q2x, q2y;
  logic signed [40:0] n1x, n1y, n2x, n2y;

  // stage F: both ratios from one quotient and its remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      tv[0] <= 1'b0;
    end else if (en) begin
      tv[0] <= vld[DivSteps];
    end
    if (en) begin
      tl[0].v1x       <= cx[DivSteps].v1x;
      tl[0].v1y       <= cx[DivSteps].v1y;
      tl[0].v2x       <= cx[DivSteps].v2x;
      tl[0].v2y       <= cx[DivSteps].v2y;
      tl[0].nxn       <= cx[DivSteps].nx[NormW-1];
      tl[0].nyn       <= cx[DivSteps].ny[NormW-1];
      tl[0].anx       <= cx[DivSteps].nx[NormW-1] ? 16'(-cx[DivSteps].nx) : cx[DivSteps].nx;
      tl[0].any_n     <= cx[DivSteps].ny[NormW-1] ? 16'(-cx[DivSteps].ny) : cx[DivSteps].ny;
      tl[0].zero_mass <= cx[DivSteps].zero_mass;
      tl[0].sep       <= cx[DivSteps].sep;
      s_f  <= cx[DivSteps].s;
      r1_f <= {1'b0, dv[DivSteps].quot};
      r2_f <= (25'd1 << QuotW) - {1'b0, dv[DivSteps].quot}
              - 25'(dv[DivSteps].rem != '0);
    end
  end

  // stages G..J carry the side record along
  for (genvar j = 1; j < TailN; j++) begin : g_tail
    always_ff @(posedge clk) begin
      if (rst) begin
        tv[j] <= 1'b0;
      end else if (en) begin
        tv[j] <= tv[j-1];
      end
      if (en) begin
        tl[j] <= tl[j-1];
      end
    end
  end

  logic [62:0] t1, t2;
  logic [53:0] m1x, m1y, m2x, m2y;

  always_comb begin
    t1  = 63'(p1lo) + {2'b0, p1hi, 18'b0} + (63'd1 << 23);
    t2  = 63'(p2lo) + {2'b0, p2hi, 18'b0} + (63'd1 << 23);
    m1x = 54'(q1x) + 54'd8192;
    m1y = 54'(q1y) + 54'd8192;
    m2x = 54'(q2x) + 54'd8192;
    m2y = 54'(q2y) + 54'd8192;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage G: s times each ratio, split on s
      p1lo <= 43'(s_f[17:0])  * 43'(r1_f);
      p1hi <= 43'(s_f[35:18]) * 43'(r1_f);
      p2lo <= 43'(s_f[17:0])  * 43'(r2_f);
      p2hi <= 43'(s_f[35:18]) * 43'(r2_f);
      // stage H: per-body speed change, rounded
      d1 <= t1[60:24];
      d2 <= t2[60:24];
      // stage I: change along each normal component
      q1x <= 53'(d1) * 53'(tl[2].anx);
      q1y <= 53'(d1) * 53'(tl[2].any_n);
      q2x <= 53'(d2) * 53'(tl[2].anx);
      q2y <= 53'(d2) * 53'(tl[2].any_n);
      // stage J: round half away from zero, apply with the normal's sign
      n1x <= tl[3].nxn ? 41'(tl[3].v1x) + signed'({2'b0, m1x[52:14]})
                       : 41'(tl[3].v1x) - signed'({2'b0, m1x[52:14]});
      n1y <= tl[3].nyn ? 41'(tl[3].v1y) + signed'({2'b0, m1y[52:14]})
                       : 41'(tl[3].v1y) - signed'({2'b0, m1y[52:14]});
      n2x <= tl[3].nxn ? 41'(tl[3].v2x) - signed'({2'b0, m2x[52:14]})
                       : 41'(tl[3].v2x) + signed'({2'b0, m2x[52:14]});
      n2y <= tl[3].nyn ? 41'(tl[3].v2y) - signed'({2'b0, m2y[52:14]})
                       : 41'(tl[3].v2y) + signed'({2'b0, m2y[52:14]});
    end
  end

  // stage K: saturate and pick the outcome into the output register
  function automatic logic signed [VelW-1:0] sat32(input logic signed [40:0] v);
    if (v > 41'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -41'sh0_8000_0000) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic is_sat(input logic signed [40:0] v);
    return (v > 41'sh0_7FFF_FFFF) || (v < -41'sh0_8000_0000);
  endfunction

  icr_out_t res;

  always_comb begin
    res = '0;
    if (tl[4].zero_mass || tl[4].sep) begin
      res.new_first_vel_x  = tl[4].v1x;
      res.new_first_vel_y  = tl[4].v1y;
      res.new_second_vel_x = tl[4].v2x;
      res.new_second_vel_y = tl[4].v2y;
      res.outcome          = tl[4].zero_mass ? OUT_ZERO_MASS : OUT_SEPARATING;
    end else begin
      res.new_first_vel_x  = sat32(n1x);
      res.new_first_vel_y  = sat32(n1y);
      res.new_second_vel_x = sat32(n2x);
      res.new_second_vel_y = sat32(n2y);
      res.outcome = (is_sat(n1x) || is_sat(n1y) || is_sat(n2x) || is_sat(n2y)) ?
                    OUT_SATURATED : OUT_APPLIED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= tv[4];
    end
    if (en) begin
      rsp.data <= res;
    end
  end

endmodule

>>> design/icr_check.sv
// icr_check: port-level assertions for impulse_collision_resolve
// depends on icr_pkg; bound to the top level below
module icr_check (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input icr_pkg::icr_out_t rsp_data
);
  import icr_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result changed while stalled");

  // a stalled output back-pressures the input
  a_bp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !req_ready)
    else $error("input taken while output stalled");

  // nothing comes out right after reset
  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result valid after reset");

  // a saturated outcome shows a velocity at a rail
  a_sat: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.outcome == OUT_SATURATED |->
      rsp_data.new_first_vel_x == 32'sh7FFF_FFFF ||
      rsp_data.new_first_vel_x == 32'sh8000_0000 ||
      rsp_data.new_first_vel_y == 32'sh7FFF_FFFF ||
      rsp_data.new_first_vel_y == 32'sh8000_0000 ||
      rsp_data.new_second_vel_x == 32'sh7FFF_FFFF ||
      rsp_data.new_second_vel_x == 32'sh8000_0000 ||
      rsp_data.new_second_vel_y == 32'sh7FFF_FFFF ||
      rsp_data.new_second_vel_y == 32'sh8000_0000)
    else $error("saturated outcome without a clamped velocity");

  logic unused_req_valid;
  assign unused_req_valid = req_valid;

endmodule

bind impulse_collision_resolve icr_check u_icr_check (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);

>>> sim/icr_scoreboard.sv
`timescale 1ns / 100ps
// icr_scoreboard: predicts and checks the resolver's results from its channels
// depends on icr_pkg, icr_in_if, icr_out_if
module icr_scoreboard (
  input  logic      clk,
  input  logic      rst,
  icr_in_if.sink    req,
  icr_out_if.sink   rsp,
  output int        errors,
  output int        pending
);
  import icr_pkg::*;

  icr_out_t expected_velocities[$];

  function automatic logic signed [63:0] comp_change(logic [63:0] d,
                                                     logic signed [NormW-1:0] n);
    logic [63:0] an;
    logic [63:0] mag;
    an  = (n < 0) ? 64'(-64'(n)) : 64'(n);
    mag = (d * an + 64'd8192) >> 14;
    return (n < 0) ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [63:0] clamp32(logic signed [63:0] v, ref logic hit);
    if (v > 64'sd2147483647) begin
      hit = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      hit = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic icr_out_t resolve_contact(icr_in_t c);
    icr_out_t r;
    logic signed [63:0] v1x, v1y, v2x, v2y, vn;
    logic [63:0] m1, m2, e, s, total, r1, r2, d1, d2;
    logic hit;
    v1x = c.first_vel_x;
    v1y = c.first_vel_y;
    v2x = c.second_vel_x;
    v2y = c.second_vel_y;
    m1 = c.first_mass;
    m2 = c.second_mass;
    hit = 1'b0;
    r.new_first_vel_x  = c.first_vel_x;
    r.new_first_vel_y  = c.first_vel_y;
    r.new_second_vel_x = c.second_vel_x;
    r.new_second_vel_y = c.second_vel_y;
    if (m1 == 0 || m2 == 0) begin
      r.outcome = OUT_ZERO_MASS;
    end else begin
      vn = (v2x - v1x) * 64'(c.normal_x) + (v2y - v1y) * 64'(c.normal_y);
      if (vn > 0) begin
        r.outcome = OUT_SEPARATING;
      end else begin
        e = (c.first_restitution < c.second_restitution) ?
            c.first_restitution : c.second_restitution;
        if (e > OneQ14) e = OneQ14;
        s = ((64'(OneQ14) + e) * 64'(-vn) + (64'd1 << 27)) >> 28;
        total = m1 + m2;
        r1 = (m2 << 24) / total;
        r2 = (m1 << 24) / total;
        d1 = (s * r1 + (64'd1 << 23)) >> 24;
        d2 = (s * r2 + (64'd1 << 23)) >> 24;
        r.new_first_vel_x  = 32'(clamp32(v1x - comp_change(d1, c.normal_x), hit));
        r.new_first_vel_y  = 32'(clamp32(v1y - comp_change(d1, c.normal_y), hit));
        r.new_second_vel_x = 32'(clamp32(v2x + comp_change(d2, c.normal_x), hit));
        r.new_second_vel_y = 32'(clamp32(v2y + comp_change(d2, c.normal_y), hit));
        r.outcome = hit ? OUT_SATURATED : OUT_APPLIED;
      end
    end
    return r;
  endfunction

  assign pending = expected_velocities.size();

  always @(posedge clk) begin
    icr_out_t want;
    if (rst) begin
      errors <= 0;
    end else begin
      if (req.valid && req.ready) expected_velocities.push_back(resolve_contact(req.data));
      if (rsp.valid && rsp.ready) begin
        if (expected_velocities.size() == 0) begin
          $display("%0t unexpected result: expected none, actual %h", $time, rsp.data);
          errors <= errors + 1;
        end else begin
          want = expected_velocities.pop_front();
          if (rsp.data !== want) begin
            $display("%0t mismatch: expected v1 %h %h v2 %h %h o %0d", $time,
                     want.new_first_vel_x, want.new_first_vel_y,
                     want.new_second_vel_x, want.new_second_vel_y, want.outcome);
            $display("%0t           actual v1 %h %h v2 %h %h o %0d", $time,
                     rsp.data.new_first_vel_x, rsp.data.new_first_vel_y,
                     rsp.data.new_second_vel_x, rsp.data.new_second_vel_y,
                     rsp.data.outcome);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

>>> sim/impulse_collision_resolve_test.sv
`timescale 1ns / 100ps
// impulse_collision_resolve_test: directed and random contact pairs into the resolver
// depends on icr_pkg, icr_in_if, icr_out_if, icr_scoreboard, impulse_collision_resolve
module impulse_collision_resolve_test;
  import icr_pkg::*;

  localparam int RandomContacts = 1000;
  localparam int CycleLimit     = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors;
  int   pending;
  int   cycles = 0;
  logic hold_off = 1'b0;

  icr_in_if  req ();
  icr_out_if rsp ();

  impulse_collision_resolve dut (.clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source));
  icr_scoreboard checker_i (.clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.sink),
                            .errors(errors), .pending(pending));

  always #2 clk = ~clk;

  // run-away guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("impulse_collision_resolve verification failed");
      $finish;
    end
  end

  // receiver: stall pattern that cycles through modes, plus one long hold-off
  always @(posedge clk) begin
    int mode;
    mode = (cycles / 500) % 4;
    if (rst || hold_off) rsp.ready <= 1'b0;
    else case (mode)
      0: rsp.ready <= 1'b1;
      1: rsp.ready <= ($urandom_range(0, 3) != 0);
      2: rsp.ready <= ($urandom_range(0, 1) != 0);
      default: rsp.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // long hold-off counted here so the pipeline fills and back-pressures
  initial begin
    int n;
    @(negedge rst);
    repeat (300) @(posedge clk);
    hold_off <= 1'b1;
    n = 0;
    while (n < 200) begin
      @(posedge clk);
      n++;
    end
    hold_off <= 1'b0;
  end

  // random velocity biased toward edges and small values
  function automatic logic [31:0] pick_vel();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(0, 2 << 16)) - (1 << 16));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_mass();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hffffffff;
      2: return 32'd1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [14:0] pick_rest();
    case ($urandom_range(0, 7))
      0: return 15'h7fff;     // above one, clamped
      1: return OneQ14;
      2: return 15'd0;
      default: return 15'($urandom_range(0, 32767));
    endcase
  endfunction

  function automatic logic [15:0] pick_norm();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed(16'sd16384) * ($urandom_range(0, 1) ? 1 : -1));
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic icr_in_t random_contact();
    icr_in_t c;
    c.first_vel_x = pick_vel();
    c.first_vel_y = pick_vel();
    c.second_vel_x = pick_vel();
    c.second_vel_y = pick_vel();
    c.first_mass = pick_mass();
    c.second_mass = pick_mass();
    c.first_restitution = pick_rest();
    c.second_restitution = pick_rest();
    c.normal_x = pick_norm();
    c.normal_y = pick_norm();
    return c;
  endfunction

  // offer one transaction and hold until accepted
  task automatic send_contact(icr_in_t c);
    req.valid <= 1'b1;
    req.data  <= c;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic idle_gap(int n);
    req.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  initial begin
    icr_in_t c;
    int burst;
    int sent;
    req.valid <= 1'b0;
    req.data  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: head-on hit, separating, zero projection, zero masses, extremes
    c = '0;
    c.first_mass = 32'h10000;
    c.second_mass = 32'h10000;
    c.first_restitution = OneQ14;
    c.second_restitution = OneQ14;
    c.normal_x = 16'sd16384;
    c.first_vel_x = 32'sh10000;
    c.second_vel_x = -32'sh10000;
    send_contact(c);                    // approaching, full bounce
    c.first_vel_x = -32'sh10000;
    c.second_vel_x = 32'sh10000;
    send_contact(c);                    // separating
    c.second_vel_x = c.first_vel_x;
    send_contact(c);                    // zero projection
    c.first_mass = 0;
    send_contact(c);                    // zero first mass
    c.first_mass = 32'h10000;
    c.second_mass = 0;
    send_contact(c);                    // zero second mass
    c.second_mass = 32'hffffffff;
    c.first_mass = 32'hffffffff;
    c.first_vel_x = 32'sh7fffffff;
    c.second_vel_x = 32'sh80000000;
    c.first_restitution = 15'h7fff;
    c.second_restitution = 15'h7fff;    // restitution clamp
    send_contact(c);                    // saturation
    c.normal_x = 16'sh8000;
    c.normal_y = 16'sh7fff;
    c.first_vel_y = 32'sh80000000;
    c.second_vel_y = 32'sh7fffffff;
    send_contact(c);                    // non-unit normal, full range
    c.first_mass = 32'd1;
    c.first_restitution = 15'd0;
    send_contact(c);
    c = '1;
    send_contact(c);
    for (int i = 0; i < 10; i++) send_contact(random_contact());
    idle_gap(2);

    // random bursts with gaps
    sent = 0;
    while (sent < RandomContacts) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst; i++) begin
        send_contact(random_contact());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
    end
    req.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("impulse_collision_resolve verification clean");
    else $display("impulse_collision_resolve verification failed");
    $finish;
  end
endmodule
